[rtl/core/swq_pkg.sv]
// Shared types and codes for the sleep/wakeup queue.
// Holds the transaction payloads, status codes, cell control and FSM state.
// No dependencies.
package swq_pkg;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_SLEEP = 1'b1;

	typedef enum logic [2:0] {
		ST_WOKEN  = 3'd0,
		ST_NONE   = 3'd1,
		ST_ACCEPT = 3'd2,
		ST_IGNORE = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef struct packed {
		logic        cmd;
		logic        has_task;
		logic [7:0]  task_id;
		logic [31:0] duration;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] woken_task;
		logic       last;
	} rsp_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_MARK,
		CELL_DROP,
		CELL_KEEP
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [7:0]  task_id;
		logic [31:0] wake;
		logic [31:0] tick;
	} cell_ctl_t;

	typedef struct packed {
		logic        valid;
		logic        due;
		logic [7:0]  task_id;
		logic [31:0] wake;
	} cell_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MARK,
		S_CHECK,
		S_SCAN
	} state_t;

endpackage

[rtl/core/swq_if.sv]
// Valid/ready channel interfaces for request and response transactions.
// Depends on swq_pkg.
interface swq_req_if;
	logic          valid;
	logic          ready;
	swq_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface swq_rsp_if;
	logic          valid;
	logic          ready;
	swq_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/core/sleep_wakeup_queue_top.sv]
// Sleep/wakeup queue: tick counter, control FSM and the chain of task cells.
// Depends on swq_pkg, swq_if and swq_cell.
//
// Usage:
//   req carries one transaction per command: a sleep (task_id, duration,
//   has_task) or a timer tick. rsp returns status, woken_task and last.
//   A sleep gives one response, valid in the cycle after acceptance.
//   A tick increments the counter, marks due entries (S_MARK) and checks
//   for any (S_CHECK); if something is due it then walks the chain
//   through every stored entry. req.ready stays low from a tick until
//   the walk ends or, with nothing due, until the check ends.
//   Each due entry leaves the head of the chain as a response, oldest
//   first, with last set on the final one; a tick with nothing due gives a
//   single response with status none. Entries that stay are rotated back
//   to the tail, so order is kept and the chain stays packed.
//   req.ready is high only between commands and while the response
//   register is free or being drained. A stalled receiver holds the
//   response register and pauses the walk at the next due entry.
//   Reset clears the tick counter, the entry count and every cell's
//   valid flag; the block is ready in the first cycle after reset.
module sleep_wakeup_queue_top #(
	parameter int SLOTS = 16
) (
	input logic       clk,
	input logic       arst_n,
	swq_req_if.sink   req,
	swq_rsp_if.source rsp
);

	localparam int CW = $clog2(SLOTS + 1);

	swq_pkg::state_t    state_q, state_d;
	swq_pkg::cell_ctl_t ctl;
	swq_pkg::cell_t     cells [SLOTS];
	swq_pkg::cell_t     nexts [SLOTS];
	swq_pkg::cell_t     head;
	swq_pkg::rsp_t      rsp_q, rsp_d;

	logic [31:0]      tick_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    steps_q;
	logic             rsp_valid_q;
	logic             emit;
	logic             out_free;
	logic             acc;
	logic             sleep_ok;
	logic             full;
	logic             advance;
	logic             any_due;
	logic             rest_due;
	logic [SLOTS-1:0] due_v;
	logic [SLOTS-1:0] valid_v;

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_chain
			logic prev_valid;
			if (g == 0) begin : g_head
				assign prev_valid = 1'b1;
			end else begin : g_body
				assign prev_valid = cells[g-1].valid;
			end
			if (g == SLOTS - 1) begin : g_tail
				assign nexts[g] = '0;
			end else begin : g_link
				assign nexts[g] = cells[g+1];
			end
			swq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.prev_valid (prev_valid),
				.next       (nexts[g]),
				.cur        (cells[g])
			);
			assign due_v[g]   = cells[g].due;
			assign valid_v[g] = cells[g].valid;
		end
	endgenerate

	assign head     = cells[0];
	assign any_due  = |due_v;
	assign rest_due = |(due_v >> 1);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == swq_pkg::S_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign sleep_ok  = req.data.has_task && (req.data.duration != 32'd0);
	assign full      = (cnt_q == CW'(SLOTS));
	assign advance   = (steps_q != '0) && (!head.due || out_free);

	always_comb begin
		state_d = state_q;
		case (state_q)
			swq_pkg::S_IDLE: begin
				if (acc && req.data.cmd == swq_pkg::CMD_TICK) begin
					state_d = swq_pkg::S_MARK;
				end
			end
			swq_pkg::S_MARK: begin
				state_d = swq_pkg::S_CHECK;
			end
			swq_pkg::S_CHECK: begin
				if (any_due) begin
					state_d = swq_pkg::S_SCAN;
				end else if (out_free) begin
					state_d = swq_pkg::S_IDLE;
				end
			end
			swq_pkg::S_SCAN: begin
				if (steps_q == '0 || (advance && steps_q == CW'(1))) begin
					state_d = swq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = swq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.op      = swq_pkg::CELL_HOLD;
		ctl.task_id = req.data.task_id;
		ctl.wake    = tick_q + req.data.duration;
		ctl.tick    = tick_q;
		emit        = 1'b0;
		rsp_d       = '{status: swq_pkg::ST_NONE, woken_task: 8'd0, last: 1'b1};
		case (state_q)
			swq_pkg::S_IDLE: begin
				if (acc && req.data.cmd == swq_pkg::CMD_SLEEP) begin
					emit = 1'b1;
					if (!sleep_ok) begin
						rsp_d.status = swq_pkg::ST_IGNORE;
					end else if (full) begin
						rsp_d.status = swq_pkg::ST_FULL;
					end else begin
						rsp_d.status     = swq_pkg::ST_ACCEPT;
						rsp_d.woken_task = req.data.task_id;
						ctl.op           = swq_pkg::CELL_APPEND;
					end
				end
			end
			swq_pkg::S_MARK: begin
				ctl.op = swq_pkg::CELL_MARK;
			end
			swq_pkg::S_CHECK: begin
				emit = !any_due && out_free;
			end
			swq_pkg::S_SCAN: begin
				ctl.task_id = head.task_id;
				ctl.wake    = head.wake;
				if (advance) begin
					if (head.due) begin
						ctl.op           = swq_pkg::CELL_DROP;
						emit             = 1'b1;
						rsp_d.status     = swq_pkg::ST_WOKEN;
						rsp_d.woken_task = head.task_id;
						rsp_d.last       = !rest_due;
					end else begin
						ctl.op = swq_pkg::CELL_KEEP;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swq_pkg::S_IDLE;
			tick_q      <= 32'd0;
			cnt_q       <= '0;
			steps_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && req.data.cmd == swq_pkg::CMD_TICK) begin
				tick_q <= tick_q + 32'd1;
			end
			if (ctl.op == swq_pkg::CELL_APPEND) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctl.op == swq_pkg::CELL_DROP) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == swq_pkg::S_CHECK) begin
				steps_q <= cnt_q;
			end else if (state_q == swq_pkg::S_SCAN && advance) begin
				steps_q <= steps_q - CW'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(SLOTS))
		else $error("entry count beyond table size");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_v & SLOTS'(valid_v + 1'b1)) == '0)
		else $error("chain has a hole");

	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_v) == int'(cnt_q))
		else $error("entry count disagrees with valid cells");

	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swq_pkg::S_SCAN |-> steps_q <= cnt_q)
		else $error("walk longer than the chain");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !emit)
		else $error("response overwritten while stalled");
`endif

endmodule

[rtl/core/swq_cell.sv]
// One slot of the sleeping-task chain: task number, wake time, valid and due flags.
// Appends at the tail, marks due entries, shifts towards the head, and takes a kept head entry back at the tail.
// Depends on swq_pkg.
module swq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  swq_pkg::cell_ctl_t ctl,
	input  logic               prev_valid,
	input  swq_pkg::cell_t     next,
	output swq_pkg::cell_t     cur
);

	logic        valid_q, valid_d;
	logic        due_q, due_d;
	logic [7:0]  task_q, task_d;
	logic [31:0] wake_q, wake_d;

	always_comb begin
		valid_d = valid_q;
		due_d   = due_q;
		task_d  = task_q;
		wake_d  = wake_q;
		case (ctl.op)
			swq_pkg::CELL_APPEND: begin
				if (!valid_q && prev_valid) begin
					valid_d = 1'b1;
					due_d   = 1'b0;
					task_d  = ctl.task_id;
					wake_d  = ctl.wake;
				end
			end
			swq_pkg::CELL_MARK: begin
				due_d = valid_q && (wake_q <= ctl.tick);
			end
			swq_pkg::CELL_DROP: begin
				valid_d = next.valid;
				due_d   = next.due;
				task_d  = next.task_id;
				wake_d  = next.wake;
			end
			swq_pkg::CELL_KEEP: begin
				// tail cell takes the head entry back, the rest move up
				if (valid_q && !next.valid) begin
					due_d  = 1'b0;
					task_d = ctl.task_id;
					wake_d = ctl.wake;
				end else begin
					valid_d = next.valid;
					due_d   = next.due;
					task_d  = next.task_id;
					wake_d  = next.wake;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			due_q   <= 1'b0;
		end else begin
			valid_q <= valid_d;
			due_q   <= due_d;
		end
	end

	always_ff @(posedge clk) begin
		task_q <= task_d;
		wake_q <= wake_d;
	end

	assign cur.valid   = valid_q;
	assign cur.due     = due_q;
	assign cur.task_id = task_q;
	assign cur.wake    = wake_q;

endmodule

[verif/tb_sleep_wakeup_queue_top.sv]
// Self-checking testbench for sleep_wakeup_queue_top: directed table, then random sleeps and ticks.
// Predicts responses from its own copy of the tick counter and sleep table, across four idling phases.
// Depends on swq_pkg, swq_if and the RTL of the block.
module tb_sleep_wakeup_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS          = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 61;

	typedef struct {
		swq_pkg::req_t item;
		bit            pinned;
		swq_pkg::rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	swq_req_if req_ch ();
	swq_rsp_if rsp_ch ();

	sleep_wakeup_queue_top #(.SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [7:0]  slot_task [SLOTS];
	logic [31:0] slot_wake [SLOTS];
	int unsigned slot_count = 0;
	logic [31:0] tick_now   = '0;

	swq_pkg::rsp_t owed_rsp[$];
	stim_row_t     directed_rows[$];

	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	bit            row_pinned     = 1'b0;
	swq_pkg::rsp_t row_want       = '0;

	int errors    = 0;
	int n_req     = 0;
	int n_rsp     = 0;
	int n_woken   = 0;
	int n_full    = 0;
	int idle_cycles = 0;

	task automatic advance_sleep_table(input swq_pkg::req_t it, input bit pinned,
			input swq_pkg::rsp_t want);
		swq_pkg::rsp_t fresh[$];
		int unsigned   keep;
		if (it.cmd == swq_pkg::CMD_SLEEP) begin
			if (!it.has_task || it.duration == 32'd0) begin
				fresh.push_back('{swq_pkg::ST_IGNORE, 8'd0, 1'b1});
			end else if (slot_count >= SLOTS) begin
				fresh.push_back('{swq_pkg::ST_FULL, 8'd0, 1'b1});
			end else begin
				slot_task[slot_count] = it.task_id;
				slot_wake[slot_count] = tick_now + it.duration;
				slot_count++;
				fresh.push_back('{swq_pkg::ST_ACCEPT, it.task_id, 1'b1});
			end
		end else begin
			tick_now = tick_now + 32'd1;
			keep = 0;
			for (int i = 0; i < slot_count; i++) begin
				if (slot_wake[i] <= tick_now) begin
					fresh.push_back('{swq_pkg::ST_WOKEN, slot_task[i], 1'b0});
				end else begin
					slot_task[keep] = slot_task[i];
					slot_wake[keep] = slot_wake[i];
					keep++;
				end
			end
			slot_count = keep;
			if (fresh.size() == 0)
				fresh.push_back('{swq_pkg::ST_NONE, 8'd0, 1'b1});
			else
				fresh[fresh.size() - 1].last = 1'b1;
		end
		if (pinned)
			owed_rsp.push_back(want);
		else
			foreach (fresh[k])
				owed_rsp.push_back(fresh[k]);
	endtask

	task automatic add_row(input logic cmd, input logic has, input logic [7:0] id,
			input logic [31:0] dur, input bit pinned, input swq_pkg::status_t st,
			input logic [7:0] tsk);
		stim_row_t r;
		r.item   = '{cmd, has, id, dur};
		r.pinned = pinned;
		r.want   = '{st, tsk, 1'b1};
		directed_rows.push_back(r);
	endtask

	task automatic send_req(input stim_row_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		row_pinned = r.pinned;
		row_want   = r.want;
		req_ch.valid <= 1'b1;
		req_ch.data  <= r.item;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic drain_responses();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (owed_rsp.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// scoreboard: predict on request transactions, compare on response transactions
	always @(posedge clk) begin
		swq_pkg::rsp_t got;
		swq_pkg::rsp_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				n_req++;
				advance_sleep_table(req_ch.data, row_pinned, row_want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				n_rsp++;
				if (got.status == swq_pkg::ST_WOKEN)
					n_woken++;
				if (got.status == swq_pkg::ST_FULL)
					n_full++;
				if (owed_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected response %s/%0d/%0d, expected none",
						$time, got.status.name(), got.woken_task, got.last);
				end else begin
					want = owed_rsp.pop_front();
					if (got.status !== want.status || got.woken_task !== want.woken_task ||
							got.last !== want.last) begin
						errors++;
						$display("%0t: response mismatch, expected %s/%0d/%0d, got %s/%0d/%0d",
							$time, want.status.name(), want.woken_task, want.last,
							got.status.name(), got.woken_task, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int        r;
		int        send_pct [4];
		int        stall_pct [4];
		send_pct  = '{0, 52, 0, 6};
		stall_pct = '{0, 0, 52, 6};

		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_task[i] = '0;
			slot_wake[i] = '0;
		end

		add_row(swq_pkg::CMD_TICK, 1'b0, 8'h00, 32'd0, 1'b1, swq_pkg::ST_NONE, 8'h00);
		add_row(swq_pkg::CMD_SLEEP, 1'b0, 8'h5A, 32'd5, 1'b1, swq_pkg::ST_IGNORE, 8'h00);
		add_row(swq_pkg::CMD_SLEEP, 1'b1, 8'h5A, 32'd0, 1'b1, swq_pkg::ST_IGNORE, 8'h00);
		add_row(swq_pkg::CMD_SLEEP, 1'b1, 8'hFF, 32'd1, 1'b1, swq_pkg::ST_ACCEPT, 8'hFF);
		// wake time wraps to zero: due on the next tick
		add_row(swq_pkg::CMD_SLEEP, 1'b1, 8'h00, 32'hFFFF_FFFF, 1'b1,
			swq_pkg::ST_ACCEPT, 8'h00);
		add_row(swq_pkg::CMD_SLEEP, 1'b1, 8'hA5, 32'd3, 1'b1, swq_pkg::ST_ACCEPT, 8'hA5);
		add_row(swq_pkg::CMD_TICK, 1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b0, swq_pkg::ST_NONE, 8'h00);
		for (int k = 0; k < SLOTS - 1; k++)
			add_row(swq_pkg::CMD_SLEEP, 1'b1, 8'(k * 17 + 3), 32'd2, 1'b1,
				swq_pkg::ST_ACCEPT, 8'(k * 17 + 3));
		add_row(swq_pkg::CMD_SLEEP, 1'b1, 8'h77, 32'd9, 1'b1, swq_pkg::ST_FULL, 8'h00);
		// ignore takes priority over full
		add_row(swq_pkg::CMD_SLEEP, 1'b0, 8'h77, 32'd9, 1'b1, swq_pkg::ST_IGNORE, 8'h00);
		add_row(swq_pkg::CMD_TICK, 1'b0, 8'h00, 32'd0, 1'b0, swq_pkg::ST_NONE, 8'h00);
		add_row(swq_pkg::CMD_TICK, 1'b0, 8'h00, 32'd0, 1'b0, swq_pkg::ST_NONE, 8'h00);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_req(directed_rows[i]);
		drain_responses();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				row.pinned = 1'b0;
				row.want   = '0;
				row.item   = '{swq_pkg::CMD_SLEEP, 1'b1, 8'($urandom_range(255)),
					32'($urandom_range(24, 1))};
				if (r < 40) begin
					row.item = '{swq_pkg::CMD_TICK, 1'($urandom_range(1)),
						8'($urandom_range(255)), 32'($urandom)};
				end else if (r < 80) begin
					// short sleep, already set
				end else if (r < 86) begin
					row.item.duration = 32'hFFFF_FFFF - 32'($urandom_range(3));
				end else if (r < 88) begin
					row.item.duration = 32'($urandom);
				end else if (r < 95) begin
					row.item.has_task = 1'b0;
					row.item.duration = 32'($urandom);
				end else begin
					row.item.duration = 32'd0;
				end
				send_req(row);
			end
			// hold the sender until every owed response is back
			drain_responses();
		end

		repeat (SLOTS + 4) @(posedge clk);
		if (owed_rsp.size() != 0) begin
			errors += owed_rsp.size();
			$display("%0t: %0d responses never arrived", $time, owed_rsp.size());
		end

		$display("Covered %0d request and %0d response transactions (%0d wakeups, %0d refusals)",
			n_req, n_rsp, n_woken, n_full);
		$display("over four idling phases with %0d mismatches", errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
